[src/sls_pkg.sv]
// Shared types and constants for the supersampled line stepper.
// No dependencies; every other file imports this package.
`default_nettype none

package sls_pkg;

	// Fixed limits of the block
	localparam int MAX_DIM   = 2048;
	localparam int MAX_SSAA  = 4;
	localparam int FRAC_BITS = 4;

	// Field and state widths
	localparam int IN_W      = 17;
	localparam int COORD_W   = 16;
	localparam int ERR_W     = 18;
	localparam int IDX_W     = 26;
	localparam int S_W       = 3;
	localparam int DIM_W     = 12;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W     = 8;
	localparam int SQ_W      = $clog2(MAX_SSAA * MAX_SSAA + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SSAA   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_e;

	// Effective (clamped) configuration
	typedef struct packed {
		logic [S_W-1:0]   ssaa;
		logic [SQ_W-1:0]  ssaa_sq;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic divide;
		logic remfix;
		logic rowmul;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic active;
		logic out_blocked;
	} dp_status_t;

	typedef struct packed {
		logic             write_enable;
		logic [IDX_W-1:0] sample_index;
		logic [COL_W-1:0] pixel_red;
		logic [COL_W-1:0] pixel_green;
		logic [COL_W-1:0] pixel_blue;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

[src/sls_if.sv]
// Request channels of the line stepper: line/step requests in, sample writes out.
// Depends on sls_pkg for field widths.
`default_nettype none

interface sls_in_if import sls_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic signed [IN_W-1:0] start_x;
	logic signed [IN_W-1:0] start_y;
	logic signed [IN_W-1:0] end_x;
	logic signed [IN_W-1:0] end_y;
	logic [COL_W-1:0]       line_red;
	logic [COL_W-1:0]       line_green;
	logic [COL_W-1:0]       line_blue;

	modport source (
		output valid, operation, start_x, start_y, end_x, end_y,
		output line_red, line_green, line_blue,
		input  ready
	);
	modport sink (
		input  valid, operation, start_x, start_y, end_x, end_y,
		input  line_red, line_green, line_blue,
		output ready
	);
endinterface

interface sls_out_if import sls_pkg::*;;
	logic             valid;
	logic             ready;
	logic             write_enable;
	logic [IDX_W-1:0] sample_index;
	logic [COL_W-1:0] pixel_red;
	logic [COL_W-1:0] pixel_green;
	logic [COL_W-1:0] pixel_blue;
	logic             last;

	modport source (
		output valid, write_enable, sample_index,
		output pixel_red, pixel_green, pixel_blue, last,
		input  ready
	);
	modport sink (
		input  valid, write_enable, sample_index,
		input  pixel_red, pixel_green, pixel_blue, last,
		output ready
	);
endinterface

`default_nettype wire

[src/sls_cfg.sv]
// Configuration registers; values are clamped as they are written.
// Depends on sls_pkg.
`default_nettype none

module sls_cfg import sls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	logic [S_W-1:0]   ssaa_clamped;
	logic [DIM_W-1:0] dim_clamped;

	// Clamp factor to [1, MAX_SSAA] and frame size to MAX_DIM
	always_comb begin
		ssaa_clamped = wr_data[S_W-1:0];
		if (ssaa_clamped == '0) begin
			ssaa_clamped = S_W'(1);
		end else if (ssaa_clamped > S_W'(MAX_SSAA)) begin
			ssaa_clamped = S_W'(MAX_SSAA);
		end
		dim_clamped = wr_data[DIM_W-1:0];
		if (dim_clamped > DIM_W'(MAX_DIM)) begin
			dim_clamped = DIM_W'(MAX_DIM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ssaa    <= S_W'(1);
			cfg_q.ssaa_sq <= SQ_W'(1);
			cfg_q.width   <= DIM_W'(640);
			cfg_q.height  <= DIM_W'(480);
		end else if (wr_en) begin
			case (reg_idx_e'(wr_index))
				REG_SSAA: begin
					cfg_q.ssaa    <= ssaa_clamped;
					cfg_q.ssaa_sq <= SQ_W'(ssaa_clamped) * SQ_W'(ssaa_clamped);
				end
				REG_WIDTH: begin
					cfg_q.width <= dim_clamped;
				end
				REG_HEIGHT: begin
					cfg_q.height <= dim_clamped;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/sls_ctrl.sv]
// Sequencer of the line stepper: accepts requests and steps the datapath.
// Depends on sls_pkg for command and status types.
`default_nettype none

module sls_ctrl import sls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_op,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_REMFIX,
		ST_ROWMUL,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept   = in_valid && ready_q;
	assign in_ready = ready_q;

	// Commands follow the state; load fires on the accepting edge
	always_comb begin
		cmd.load   = accept && (in_op == OP_LOAD);
		cmd.setup  = (state_q == ST_SETUP);
		cmd.divide = (state_q == ST_DIV);
		cmd.remfix = (state_q == ST_REMFIX);
		cmd.rowmul = (state_q == ST_ROWMUL);
		cmd.emit   = (state_q == ST_EMIT) && !status.out_blocked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_LOAD) begin
							state_q <= ST_SETUP;
							ready_q <= 1'b0;
						end else if (status.active) begin
							state_q <= ST_DIV;
							ready_q <= 1'b0;
						end
						// a step with no line loaded is simply dropped
					end
				end
				ST_SETUP: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
				ST_DIV: begin
					state_q <= ST_REMFIX;
				end
				ST_REMFIX: begin
					state_q <= ST_ROWMUL;
				end
				ST_ROWMUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the result register is free
					if (!status.out_blocked) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[src/sls_dp.sv]
// Line state, sample index path and result register of the line stepper.
// Depends on sls_pkg; driven by sls_ctrl commands and sls_cfg values.
`default_nettype none

module sls_dp import sls_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	input  cfg_t                   cfg,
	input  logic signed [IN_W-1:0] start_x,
	input  logic signed [IN_W-1:0] start_y,
	input  logic signed [IN_W-1:0] end_x,
	input  logic signed [IN_W-1:0] end_y,
	input  logic [3*COL_W-1:0]     colour,
	input  logic                   out_ready,
	output logic                   out_valid,
	output result_t                result,
	output dp_status_t             status
);

	localparam int P_W      = IN_W + S_W + 1;
	localparam int RECIP_SH = 17;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = COORD_W + RECIP_W;
	localparam int REM_W    = COORD_W + S_W;
	localparam int SUB_W    = 2 * S_W;
	localparam logic signed [P_W-1:0] Q_MAX = P_W'(2 ** (COORD_W - 1) - 1);
	localparam logic signed [P_W-1:0] Q_MIN = P_W'(-(2 ** (COORD_W - 1)));

	// Scale a fixed-point coordinate to samples, truncating toward zero, saturating
	function automatic logic signed [COORD_W-1:0] to_sample(
		input logic signed [IN_W-1:0] v,
		input logic [S_W-1:0]         s
	);
		logic signed [P_W-1:0] v_ext;
		logic signed [P_W-1:0] s_ext;
		logic signed [P_W-1:0] p;
		logic signed [P_W-1:0] bias;
		logic signed [P_W-1:0] q;
		v_ext = P_W'(v);
		s_ext = P_W'({1'b0, s});
		p     = v_ext * s_ext;
		bias  = p[P_W-1] ? P_W'((1 << FRAC_BITS) - 1) : '0;
		q     = (p + bias) >>> FRAC_BITS;
		if (q > Q_MAX) begin
			q = Q_MAX;
		end else if (q < Q_MIN) begin
			q = Q_MIN;
		end
		return COORD_W'(q);
	endfunction

	// floor(2^17 / s); the remainder step corrects the quotient by one
	function automatic logic [RECIP_W-1:0] recip(input logic [S_W-1:0] s);
		case (s)
			3'd2:    return RECIP_W'(65536);
			3'd3:    return RECIP_W'(43690);
			3'd4:    return RECIP_W'(32768);
			3'd5:    return RECIP_W'(26214);
			3'd6:    return RECIP_W'(21845);
			3'd7:    return RECIP_W'(18724);
			default: return RECIP_W'(131072);
		endcase
	endfunction

	// Quotient and remainder from the reciprocal product
	function automatic logic [COORD_W+S_W-1:0] div_fix(
		input logic [COORD_W-1:0] x,
		input logic [PROD_W-1:0]  prod,
		input logic [S_W-1:0]     s
	);
		logic [COORD_W-1:0] q0;
		logic [REM_W-1:0]   q0s;
		logic [REM_W-1:0]   r;
		logic [COORD_W-1:0] q;
		logic [S_W-1:0]     rem;
		q0  = prod[RECIP_SH +: COORD_W];
		q0s = REM_W'(q0) * REM_W'(s);
		r   = REM_W'(x) - q0s;
		if (r >= REM_W'(s)) begin
			q   = q0 + 1'b1;
			rem = S_W'(r - REM_W'(s));
		end else begin
			q   = q0;
			rem = S_W'(r);
		end
		return {q, rem};
	endfunction

	// Line state
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [COORD_W-1:0]        dx_q, dy_q;
	logic                      dir_x_q, dir_y_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [3*COL_W-1:0]        colour_q;
	logic                      active_q;

	// Index path stages
	logic [PROD_W-1:0]  prod_x_s1, prod_y_s1;
	logic [COORD_W-1:0] px_s2, py_s2;
	logic [S_W-1:0]     sx_s2, sy_s2;
	logic               inside_s2;
	logic [IDX_W-1:0]   lin_s3;
	logic [SUB_W-1:0]   sub_s3;
	logic               inside_s3;

	// Result register
	result_t res_q;
	logic    out_valid_q;

	// Setup terms
	logic signed [COORD_W:0] diff_x, diff_y;
	logic signed [COORD_W:0] abs_x, abs_y;
	logic [ERR_W-1:0]        err_init;

	always_comb begin
		diff_x   = (COORD_W+1)'(goal_x_q) - (COORD_W+1)'(cur_x_q);
		diff_y   = (COORD_W+1)'(goal_y_q) - (COORD_W+1)'(cur_y_q);
		abs_x    = diff_x[COORD_W] ? -diff_x : diff_x;
		abs_y    = diff_y[COORD_W] ? -diff_y : diff_y;
		err_init = ERR_W'(abs_x[COORD_W-1:0]) - ERR_W'(abs_y[COORD_W-1:0]);
	end

	// Remainder correction
	logic [COORD_W+S_W-1:0] div_x, div_y;
	logic                   inside_now;

	always_comb begin
		div_x      = div_fix(cur_x_q[COORD_W-1:0], prod_x_s1, cfg.ssaa);
		div_y      = div_fix(cur_y_q[COORD_W-1:0], prod_y_s1, cfg.ssaa);
		inside_now = !cur_x_q[COORD_W-1] && !cur_y_q[COORD_W-1] &&
			(div_x[S_W +: COORD_W] < COORD_W'(cfg.width)) &&
			(div_y[S_W +: COORD_W] < COORD_W'(cfg.height));
	end

	// Final index and Bresenham update
	logic [IDX_W-1:0]      idx_full;
	logic                  at_end;
	logic signed [ERR_W:0] e2, ext_dx, ext_dy, neg_dy, err_nx;
	logic                  step_x, step_y;

	always_comb begin
		idx_full = lin_s3 * IDX_W'(cfg.ssaa_sq) + IDX_W'(sub_s3);
		at_end   = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
		e2       = {err_q, 1'b0};
		ext_dx   = (ERR_W+1)'(dx_q);
		ext_dy   = (ERR_W+1)'(dy_q);
		neg_dy   = -ext_dy;
		step_x   = (e2 >= neg_dy);
		step_y   = (e2 <= ext_dx);
		err_nx   = (ERR_W+1)'(err_q) + (step_x ? neg_dy : '0) + (step_y ? ext_dx : '0);
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			dir_x_q  <= 1'b0;
			dir_y_q  <= 1'b0;
			err_q    <= '0;
			colour_q <= '0;
			active_q <= 1'b0;
		end else if (cmd.load) begin
			cur_x_q  <= to_sample(start_x, cfg.ssaa);
			cur_y_q  <= to_sample(start_y, cfg.ssaa);
			goal_x_q <= to_sample(end_x, cfg.ssaa);
			goal_y_q <= to_sample(end_y, cfg.ssaa);
			colour_q <= colour;
		end else if (cmd.setup) begin
			dx_q     <= abs_x[COORD_W-1:0];
			dy_q     <= abs_y[COORD_W-1:0];
			dir_x_q  <= !(cur_x_q < goal_x_q);
			dir_y_q  <= !(cur_y_q < goal_y_q);
			err_q    <= signed'(err_init);
			active_q <= 1'b1;
		end else if (cmd.emit) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_nx[ERR_W-1:0];
				if (step_x) begin
					cur_x_q <= dir_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				end
				if (step_y) begin
					cur_y_q <= dir_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
				end
			end
		end
	end

	// Index path stages
	always_ff @(posedge clk) begin
		if (cmd.divide) begin
			prod_x_s1 <= PROD_W'(cur_x_q[COORD_W-1:0]) * PROD_W'(recip(cfg.ssaa));
			prod_y_s1 <= PROD_W'(cur_y_q[COORD_W-1:0]) * PROD_W'(recip(cfg.ssaa));
		end
		if (cmd.remfix) begin
			px_s2     <= div_x[S_W +: COORD_W];
			sx_s2     <= div_x[S_W-1:0];
			py_s2     <= div_y[S_W +: COORD_W];
			sy_s2     <= div_y[S_W-1:0];
			inside_s2 <= inside_now;
		end
		if (cmd.rowmul) begin
			lin_s3    <= IDX_W'(px_s2) + IDX_W'(py_s2) * IDX_W'(cfg.width);
			sub_s3    <= SUB_W'(sy_s2) * SUB_W'(cfg.ssaa) + SUB_W'(sx_s2);
			inside_s3 <= inside_s2;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.write_enable <= inside_s3;
			res_q.sample_index <= inside_s3 ? idx_full : '0;
			res_q.pixel_red    <= colour_q[COL_W-1:0];
			res_q.pixel_green  <= colour_q[2*COL_W-1:COL_W];
			res_q.pixel_blue   <= colour_q[3*COL_W-1:2*COL_W];
			res_q.last         <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid          = out_valid_q;
	assign result             = res_q;
	assign status.active      = active_q;
	assign status.out_blocked = out_valid_q && !out_ready;

endmodule

`default_nettype wire

[src/supersampled_line_stepper.sv]
// Supersampled line stepper top level: config registers, sequencer, datapath.
// Depends on sls_pkg, sls_if, sls_cfg, sls_ctrl and sls_dp.
//
// A load request (operation 0) scales both endpoints into sample space and
// latches the colour when accepted; the setup state then computes deltas and
// error term before the input reopens. Each step request on an active line
// yields one sample write: the sequencer walks the index path through
// reciprocal multiply, remainder correction and row multiply, and the
// sample-square multiply feeds the result register as it loads; the next
// request is taken in the cycle after that load. A step with no line loaded
// is taken and gives nothing. The result register decouples the output: a
// load may be taken while a sample waits there, and a step holds in its last
// stage until the register frees. Configuration writes are for idle periods;
// values are clamped on write.
`default_nettype none

module supersampled_line_stepper import sls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sls_in_if.sink               in_ch,
	sls_out_if.source            out_ch,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;
	result_t    result;
	logic       out_valid;

	sls_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	sls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.start_x   (in_ch.start_x),
		.start_y   (in_ch.start_y),
		.end_x     (in_ch.end_x),
		.end_y     (in_ch.end_y),
		.colour    ({in_ch.line_blue, in_ch.line_green, in_ch.line_red}),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.result    (result),
		.status    (status)
	);

	// Output channel
	assign out_ch.valid        = out_valid;
	assign out_ch.write_enable = result.write_enable;
	assign out_ch.sample_index = result.sample_index;
	assign out_ch.pixel_red    = result.pixel_red;
	assign out_ch.pixel_green  = result.pixel_green;
	assign out_ch.pixel_blue   = result.pixel_blue;
	assign out_ch.last         = result.last;

endmodule

`default_nettype wire

[src/sls_checker.sv]
// Port-level checks for the supersampled line stepper, bound to the top level.
// Depends on sls_pkg and supersampled_line_stepper.
`default_nettype none

module sls_checker import sls_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_op,
	input logic             out_valid,
	input logic             out_ready,
	input logic             out_we,
	input logic [IDX_W-1:0] out_idx,
	input logic [COL_W-1:0] out_red,
	input logic [COL_W-1:0] out_green,
	input logic [COL_W-1:0] out_blue,
	input logic             out_last
);

	logic in_take;
	assign in_take = in_valid && in_ready;

	// A stalled sample write keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_idx) && $stable(out_we) &&
			$stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_last))
		else $error("stalled sample write changed");

	// Clipped samples carry index zero
	a_clip_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_we |-> out_idx == '0)
		else $error("clipped sample with nonzero index");

	// No request can produce a sample in the very next cycle
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !out_valid |=> !out_valid)
		else $error("sample appeared one cycle after a request");

	// A line load keeps the input closed during its setup state
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && in_op == OP_LOAD |=> !in_ready)
		else $error("request taken during line setup");

endmodule

bind supersampled_line_stepper sls_checker u_sls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.operation),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_we    (out_ch.write_enable),
	.out_idx   (out_ch.sample_index),
	.out_red   (out_ch.pixel_red),
	.out_green (out_ch.pixel_green),
	.out_blue  (out_ch.pixel_blue),
	.out_last  (out_ch.last)
);

`default_nettype wire

[tb/sv/supersampled_line_stepper_test.sv]
// Self-checking bench for the supersampled line stepper: line and step requests in,
// sample writes checked against an in-bench Bresenham predictor.
// Depends on sls_pkg, the sls_in_if/sls_out_if channels and the block itself.

module supersampled_line_stepper_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sls_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 300;
	localparam int BATCHES       = 12;
	localparam int BATCH_ITEMS   = 104;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		op_e                    operation;
		logic signed [IN_W-1:0] start_x;
		logic signed [IN_W-1:0] start_y;
		logic signed [IN_W-1:0] end_x;
		logic signed [IN_W-1:0] end_y;
		logic [COL_W-1:0]       red;
		logic [COL_W-1:0]       green;
		logic [COL_W-1:0]       blue;
	} line_req_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sls_in_if  in_ch();
	sls_out_if out_ch();

	supersampled_line_stepper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies, reset values
	logic [S_W-1:0]   reg_ssaa   = 3'd1;
	logic [DIM_W-1:0] reg_width  = 12'd640;
	logic [DIM_W-1:0] reg_height = 12'd480;

	// Line state of the predictor
	logic signed [COORD_W-1:0] at_x, at_y, goal_x, goal_y;
	logic [COORD_W-1:0]        span_x, span_y;
	logic                      dir_x_neg, dir_y_neg;
	logic signed [ERR_W-1:0]   bres_err;
	logic [COL_W-1:0]          ink_red, ink_green, ink_blue;
	logic                      line_live = 1'b0;

	line_req_t line_requests[$];
	line_req_t on_bus;
	result_t   due_samples[$];

	int  tx_idle_pct = 37;
	int  rx_idle_pct = 68;
	int  batch_no    = -1;
	bit  rx_hold;
	int  fault_count;
	int  cycle_count;
	int  loads_taken;
	int  samples_checked;
	int  samples_written;
	int  lines_ended;
	int  settings_used = 1;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int ssaa_eff();
		int s;
		s = reg_ssaa;
		if (s < 1) s = 1;
		if (s > MAX_SSAA) s = MAX_SSAA;
		return s;
	endfunction

	function automatic int dim_eff(input logic [DIM_W-1:0] d);
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// Fixed-point pixel coordinate to sample coordinate, truncating toward zero
	function automatic logic signed [COORD_W-1:0] scale_to_samples(
		input logic signed [IN_W-1:0] v, input int s);
		longint p;
		longint q;
		p = longint'(v) * s;
		q = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[COORD_W-1:0];
	endfunction

	function automatic int clip_fixed(input int v);
		if (v > 65535) return 65535;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endfunction

	// Apply one accepted request to the predictor; queue the sample it yields
	task automatic rasterize_request(input line_req_t req);
		int      s, w, h, dx, dy, e2, err, ux, uy;
		longint  idx;
		result_t smp;
		s = ssaa_eff();
		if (req.operation == OP_LOAD) begin
			at_x   = scale_to_samples(req.start_x, s);
			at_y   = scale_to_samples(req.start_y, s);
			goal_x = scale_to_samples(req.end_x, s);
			goal_y = scale_to_samples(req.end_y, s);
			dx = int'(goal_x) - int'(at_x);
			dy = int'(goal_y) - int'(at_y);
			span_x = COORD_W'(abs_int(dx));
			span_y = COORD_W'(abs_int(dy));
			dir_x_neg = !(at_x < goal_x);
			dir_y_neg = !(at_y < goal_y);
			err = int'(span_x) - int'(span_y);
			bres_err  = ERR_W'(err);
			ink_red   = req.red;
			ink_green = req.green;
			ink_blue  = req.blue;
			line_live = 1'b1;
			loads_taken++;
		end else if (line_live) begin
			w = dim_eff(reg_width);
			h = dim_eff(reg_height);
			smp = '0;
			smp.pixel_red   = ink_red;
			smp.pixel_green = ink_green;
			smp.pixel_blue  = ink_blue;
			smp.last = (at_x == goal_x) && (at_y == goal_y);
			// negative samples count as outside the frame
			if (at_x >= 0 && at_y >= 0) begin
				ux = int'(at_x);
				uy = int'(at_y);
				if (ux / s < w && uy / s < h) begin
					idx = (longint'(ux / s) + longint'(uy / s) * w) * s * s
						+ longint'(uy % s) * s + ux % s;
					smp.write_enable = 1'b1;
					smp.sample_index = idx[IDX_W-1:0];
				end
			end
			due_samples.push_back(smp);
			if (smp.last) begin
				line_live = 1'b0;
			end else begin
				// one Bresenham step; both tests use the pre-step error
				e2  = 2 * int'(bres_err);
				err = int'(bres_err);
				if (e2 >= -int'(span_y)) begin
					err -= int'(span_y);
					at_x = dir_x_neg ? at_x - COORD_W'(1) : at_x + COORD_W'(1);
				end
				if (e2 <= int'(span_x)) begin
					err += int'(span_x);
					at_y = dir_y_neg ? at_y - COORD_W'(1) : at_y + COORD_W'(1);
				end
				bres_err = ERR_W'(err);
			end
		end
	endtask

	task automatic push_load(input int sx, input int sy, input int ex, input int ey,
		input logic [23:0] rgb);
		line_req_t r;
		r.operation = OP_LOAD;
		r.start_x = IN_W'(sx);
		r.start_y = IN_W'(sy);
		r.end_x   = IN_W'(ex);
		r.end_y   = IN_W'(ey);
		r.red     = rgb[23:16];
		r.green   = rgb[15:8];
		r.blue    = rgb[7:0];
		line_requests.push_back(r);
	endtask

	// Step requests carry junk in the fields the block ignores
	task automatic push_steps(input int n);
		line_req_t r;
		repeat (n) begin
			r.operation = OP_STEP;
			r.start_x = IN_W'($urandom);
			r.start_y = IN_W'($urandom);
			r.end_x   = IN_W'($urandom);
			r.end_y   = IN_W'($urandom);
			r.red     = COL_W'($urandom);
			r.green   = COL_W'($urandom);
			r.blue    = COL_W'($urandom);
			line_requests.push_back(r);
		end
	endtask

	// Mostly complete short lines, some cut short or overrun, some noise
	task automatic queue_random_batch(input int quota);
		int left, roll, s, w, h, x0, y0, x1, y1, reach, nsteps;
		left = quota;
		s = ssaa_eff();
		w = dim_eff(reg_width);
		h = dim_eff(reg_height);
		while (left > 0) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				nsteps = $urandom_range(3);
				push_load(int'($urandom_range(131071)) - 65536,
					int'($urandom_range(131071)) - 65536,
					int'($urandom_range(131071)) - 65536,
					int'($urandom_range(131071)) - 65536, 24'($urandom));
				push_steps(nsteps);
				left -= 1 + nsteps;
			end else if (roll < 12) begin
				push_steps(1);
				left -= 1;
			end else begin
				reach = ($urandom_range(19) == 0) ? 40 : 8;
				x0 = clip_fixed((int'($urandom_range(w + 4)) - 2) * 16
					+ int'($urandom_range(15)));
				y0 = clip_fixed((int'($urandom_range(h + 4)) - 2) * 16
					+ int'($urandom_range(15)));
				x1 = clip_fixed(x0 + int'($urandom_range(2 * reach * 16 / s))
					- reach * 16 / s);
				y1 = clip_fixed(y0 + int'($urandom_range(2 * reach * 16 / s))
					- reach * 16 / s);
				nsteps = 1 + abs_int(int'(scale_to_samples(x1, s))
					- int'(scale_to_samples(x0, s)));
				if (nsteps < 1 + abs_int(int'(scale_to_samples(y1, s))
					- int'(scale_to_samples(y0, s))))
					nsteps = 1 + abs_int(int'(scale_to_samples(y1, s))
						- int'(scale_to_samples(y0, s)));
				if ($urandom_range(9) == 0)
					nsteps = $urandom_range(nsteps, 1);
				else if ($urandom_range(11) == 0)
					nsteps++;
				push_load(x0, y0, x1, y1, 24'($urandom));
				push_steps(nsteps);
				left -= 1 + nsteps;
			end
		end
	endtask

	task automatic write_reg(input reg_idx_e idx, input int unsigned value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SSAA:   reg_ssaa   = value[S_W-1:0];
			REG_WIDTH:  reg_width  = value[DIM_W-1:0];
			REG_HEIGHT: reg_height = value[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_until_drained();
		while (line_requests.size() != 0 || in_ch.valid || due_samples.size() != 0)
			@(negedge clk);
	endtask

	// Request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				rasterize_request(on_bus);
			if (!in_ch.valid || in_ch.ready) begin
				if (line_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					on_bus               <= line_requests[0];
					in_ch.valid          <= 1'b1;
					in_ch.operation      <= line_requests[0].operation;
					in_ch.start_x        <= line_requests[0].start_x;
					in_ch.start_y        <= line_requests[0].start_y;
					in_ch.end_x          <= line_requests[0].end_x;
					in_ch.end_y          <= line_requests[0].end_y;
					in_ch.line_red       <= line_requests[0].red;
					in_ch.line_green     <= line_requests[0].green;
					in_ch.line_blue      <= line_requests[0].blue;
					void'(line_requests.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Sample monitor and checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.write_enable = out_ch.write_enable;
				got.sample_index = out_ch.sample_index;
				got.pixel_red    = out_ch.pixel_red;
				got.pixel_green  = out_ch.pixel_green;
				got.pixel_blue   = out_ch.pixel_blue;
				got.last         = out_ch.last;
				if (due_samples.size() == 0) begin
					note_fault($sformatf("sample with none due: we=%0b idx=%0d last=%0b",
						got.write_enable, got.sample_index, got.last));
				end else begin
					want = due_samples.pop_front();
					samples_checked++;
					if (want.write_enable) samples_written++;
					if (want.last) lines_ended++;
					if (got.write_enable !== want.write_enable
						|| got.sample_index !== want.sample_index
						|| got.pixel_red !== want.pixel_red
						|| got.pixel_green !== want.pixel_green
						|| got.pixel_blue !== want.pixel_blue
						|| got.last !== want.last)
						note_fault($sformatf(
							"exp we=%0b idx=%0d rgb=%h%h%h last=%0b, got we=%0b idx=%0d rgb=%h%h%h last=%0b",
							want.write_enable, want.sample_index, want.pixel_red,
							want.pixel_green, want.pixel_blue, want.last,
							got.write_enable, got.sample_index, got.pixel_red,
							got.pixel_green, got.pixel_blue, got.last));
				end
			end
			out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Long receiver hold-off while the sender keeps offering requests
	initial begin
		while (batch_no != 9)
			@(negedge clk);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples still due",
				cycle_count, due_samples.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: directed lines, then batches under changing registers and idling
	initial begin
		int s_plan[BATCHES];
		int w_plan[BATCHES];
		int h_plan[BATCHES];
		s_plan = '{4, 1, 0, 7, 3, 2, 5, 1, 4, 2, 0, 3};
		w_plan = '{2048, 640, 0, 4095, 1, 100, 17, 2048, 64, 320, 0, 33};
		h_plan = '{2048, 480, 0, 4095, 1, 60, 2047, 1, 32, 240, 0, 9};
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = REG_SSAA;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.operation = OP_STEP;
		in_ch.start_x   = '0;
		in_ch.start_y   = '0;
		in_ch.end_x     = '0;
		in_ch.end_y     = '0;
		in_ch.line_red  = '0;
		in_ch.line_green = '0;
		in_ch.line_blue = '0;
		out_ch.ready    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// step before any line is loaded
		push_steps(1);
		// short diagonal, then a step past its end
		push_load(2 * 16 + 5, 16, 5 * 16, 3 * 16, 24'hFF00A5);
		push_steps(5);
		// fraction truncated toward zero, starts above the frame
		push_load(-8, -40, 5 * 16 + 15, 16, 24'h12AB34);
		push_steps(6);
		// full-range endpoints, black
		push_load(-65536, 65535, 65535, -65536, 24'h000000);
		push_steps(2);
		// single sample right of the frame, white
		push_load(700 * 16, 100 * 16, 700 * 16, 100 * 16, 24'hFFFFFF);
		push_steps(1);
		// last column and row, left unfinished across the register change
		push_load(639 * 16 + 15, 479 * 16 + 15, 639 * 16, 470 * 16, 24'h5A3C81);
		push_steps(3);

		for (int b = 0; b < BATCHES; b++) begin
			wait_until_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (b == 10) begin
				s_plan[b] = $urandom_range(7);
				w_plan[b] = $urandom_range(4095);
				h_plan[b] = $urandom_range(4095);
			end
			write_reg(REG_SSAA, s_plan[b]);
			write_reg(REG_WIDTH, w_plan[b]);
			write_reg(REG_HEIGHT, h_plan[b]);
			settings_used++;
			@(negedge clk);
			batch_no = b;
			if (b < 4) begin
				tx_idle_pct = 37;
				rx_idle_pct = 68;
			end else if (b < 8) begin
				tx_idle_pct = 68;
				rx_idle_pct = 37;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (b == 0) begin
				// continue the carried-over line under new indexing, then the far corner
				push_steps(2);
				push_load(2047 * 16 + 15, 2047 * 16 + 15, 2048 * 16, 2047 * 16 + 15,
					24'h7F807F);
				push_steps(2);
			end
			queue_random_batch(BATCH_ITEMS);
		end

		wait_until_drained();
		repeat (SETTLE_CYCLES + 2) @(posedge clk);
		$display("Covered %0d line loads and %0d samples (%0d inside the frame, %0d line ends)",
			loads_taken, samples_checked, samples_written, lines_ended);
		$display("over %0d register settings with sender/receiver idling and a %0d-cycle stall",
			settings_used, HOLD_CYCLES);
		if (fault_count == 0 && due_samples.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d samples never arrived", fault_count,
				due_samples.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
src/sls_pkg.sv
src/sls_if.sv
src/sls_cfg.sv
src/sls_ctrl.sv
src/sls_dp.sv
src/supersampled_line_stepper.sv
src/sls_checker.sv
tb/sv/supersampled_line_stepper_test.sv
